// File: hdl/pbs_pkg.sv
// Shared types, reset values and register indexes for the power button sequencer.
package pbs_pkg;

    localparam int unsigned CntW = 16;

    localparam logic [CntW-1:0] RESET_HOLD          = 16'd100;
    localparam logic [CntW-1:0] RST_SHORT_PRESS     = 16'd100;
    localparam logic [CntW-1:0] RST_LONG_PRESS      = 16'd1000;
    localparam logic [CntW-1:0] RST_FAULT_TICKS     = 16'd100;
    localparam logic [CntW-1:0] RST_ENABLE_DELAY    = 16'd500;
    localparam logic [CntW-1:0] RST_RELEASE_DELAY   = 16'd1;
    localparam logic [CntW-1:0] RST_BOOT_DELAY      = 16'd500;
    localparam logic [CntW-1:0] RST_BOOT_BLINK      = 16'd1000;
    localparam logic [CntW-1:0] RST_FAULT_BLINK     = 16'd150;

    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SHORT_PRESS   = 3'd0,
        REG_LONG_PRESS    = 3'd1,
        REG_FAULT_TICKS   = 3'd2,
        REG_ENABLE_DELAY  = 3'd3,
        REG_RELEASE_DELAY = 3'd4,
        REG_BOOT_DELAY    = 3'd5,
        REG_BOOT_BLINK    = 3'd6,
        REG_FAULT_BLINK   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CntW-1:0] short_press_ticks;
        logic [CntW-1:0] long_press_ticks;
        logic [CntW-1:0] fault_ticks;
        logic [CntW-1:0] power_enable_delay;
        logic [CntW-1:0] reset_release_delay;
        logic [CntW-1:0] boot_release_delay;
        logic [CntW-1:0] boot_blink_period;
        logic [CntW-1:0] fault_blink_period;
    } cfg_t;

    typedef struct packed {
        logic [CntW-1:0] hold_count;
        logic [CntW-1:0] fault_count;
        logic [CntW-1:0] reset_countdown;
        logic [CntW-1:0] boot_countdown;
        logic [CntW-1:0] enable_countdown;
        logic [CntW-1:0] blink_count;
        logic            power_flag;
        logic            boot_flag;
        logic            input_switch;
        logic            output_switch;
        logic            reset_line;
        logic            boot_line;
        logic            led_state;
    } state_t;

    typedef struct packed {
        logic input_power_en;
        logic output_power_en;
        logic target_reset_n;
        logic boot_select;
        logic led_lit;
        logic power_on;
        logic boot_mode;
        logic power_fault;
        logic monitor_start;
        logic reset_released;
    } result_t;

    // Drop both switches, the LED and the mode flags.
    function automatic state_t cut_power(input state_t s);
        state_t r;
        r = s;
        r.output_switch = 1'b0;
        r.input_switch  = 1'b0;
        r.led_state     = 1'b0;
        r.power_flag    = 1'b0;
        r.boot_flag     = 1'b0;
        return r;
    endfunction

endpackage

// File: hdl/power_button_sequencer_unit.sv
// Top level of the power button sequencer: input stage, tick update and result stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | receive   | in_valid / in_stall  | button_pressed, fault_active,
//          |           |                      | external_supply
//  out     | send      | out_valid / out_stall| input_power_en .. reset_released
//  cfg     | receive   | cfg_we               | cfg_index, cfg_data
//
//  One tick item per clock while out is not stalled; a result is valid once its tick has
//  passed the input register, which loads at the transfer edge, and then the result register.
//  The tick update is one combinational pass between those two registers.
//  Reset loads the register defaults and the power-up state (hold count 100, LED lit).
//  A stall on out holds the result register; in stalls only when the input
//  register is full and cannot move on.
module power_button_sequencer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // tick input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        button_pressed,
    input  logic                        fault_active,
    input  logic                        external_supply,
    // result output
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        input_power_en,
    output logic                        output_power_en,
    output logic                        target_reset_n,
    output logic                        boot_select,
    output logic                        led_lit,
    output logic                        power_on,
    output logic                        boot_mode,
    output logic                        power_fault,
    output logic                        monitor_start,
    output logic                        reset_released,
    // configuration
    input  logic                        cfg_we,
    input  logic [pbs_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [pbs_pkg::CntW-1:0]    cfg_data
);
    import pbs_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic    in_valid_reg;
    logic    btn_reg;
    logic    fault_reg;
    logic    ext_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;
    logic    in_xfer;

    // Move the held tick into the result register when that register is free
    // or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    pbs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbs_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .button_pressed  (btn_reg),
        .fault_active    (fault_reg),
        .external_supply (ext_reg),
        .cfg             (cfg),
        .result          (result)
    );

    // Input stage: valid bit under reset, payload captured on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            btn_reg   <= button_pressed;
            fault_reg <= fault_active;
            ext_reg   <= external_supply;
        end
    end

    // Result stage: hold while stalled, load on advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign input_power_en  = out_reg.input_power_en;
    assign output_power_en = out_reg.output_power_en;
    assign target_reset_n  = out_reg.target_reset_n;
    assign boot_select     = out_reg.boot_select;
    assign led_lit         = out_reg.led_lit;
    assign power_on        = out_reg.power_on;
    assign boot_mode       = out_reg.boot_mode;
    assign power_fault     = out_reg.power_fault;
    assign monitor_start   = out_reg.monitor_start;
    assign reset_released  = out_reg.reset_released;

`ifndef SYNTHESIS
    // A tick that moves on always shows up as a result next cycle.
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced tick did not reach the result register");

    // A held tick that cannot move on keeps its payload.
    a_held_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(btn_reg) && $stable(fault_reg) && $stable(ext_reg)))
        else $error("held tick lost or overwritten");

    // A new transfer never lands on a full input stage unless that stage moves on.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> (!in_valid_reg || advance))
        else $error("input stage overrun");

    // A stalled result is not replaced.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !advance)
        else $error("stalled result replaced");
`endif

endmodule

// File: hdl/pbs_cfg_regs.sv
// Configuration register bank for the power button sequencer.
module pbs_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pbs_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [pbs_pkg::CntW-1:0]    cfg_data,
    output pbs_pkg::cfg_t               cfg
);
    import pbs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SHORT_PRESS:   cfg_next.short_press_ticks   = cfg_data;
                REG_LONG_PRESS:    cfg_next.long_press_ticks    = cfg_data;
                REG_FAULT_TICKS:   cfg_next.fault_ticks         = cfg_data;
                REG_ENABLE_DELAY:  cfg_next.power_enable_delay  = cfg_data;
                REG_RELEASE_DELAY: cfg_next.reset_release_delay = cfg_data;
                REG_BOOT_DELAY:    cfg_next.boot_release_delay  = cfg_data;
                REG_BOOT_BLINK:    cfg_next.boot_blink_period   = cfg_data;
                REG_FAULT_BLINK:   cfg_next.fault_blink_period  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_press_ticks   <= RST_SHORT_PRESS;
            cfg_reg.long_press_ticks    <= RST_LONG_PRESS;
            cfg_reg.fault_ticks         <= RST_FAULT_TICKS;
            cfg_reg.power_enable_delay  <= RST_ENABLE_DELAY;
            cfg_reg.reset_release_delay <= RST_RELEASE_DELAY;
            cfg_reg.boot_release_delay  <= RST_BOOT_DELAY;
            cfg_reg.boot_blink_period   <= RST_BOOT_BLINK;
            cfg_reg.fault_blink_period  <= RST_FAULT_BLINK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/pbs_core.sv
// Sequencer state and the one-tick update of that state.
module pbs_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             button_pressed,
    input  logic             fault_active,
    input  logic             external_supply,
    input  pbs_pkg::cfg_t    cfg,
    output pbs_pkg::result_t result
);
    import pbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_t          s;
        logic            mon;
        logic            rel;
        logic            blink_on;
        logic [CntW-1:0] period;

        s   = state_reg;
        mon = 1'b0;
        rel = 1'b0;

        // fault counting while powered
        if (s.power_flag && fault_active)
        begin
            s.fault_count = s.fault_count + 16'd1;
            if (s.fault_count == cfg.fault_ticks)
            begin
                s = cut_power(s);
            end
        end

        // reset release countdown
        if (s.reset_countdown != '0)
        begin
            s.reset_countdown = s.reset_countdown - 16'd1;
            if (s.reset_countdown == '0)
            begin
                s.reset_line = 1'b1;
                rel          = 1'b1;
            end
        end

        // LED blink, fault pattern wins over boot pattern
        blink_on = (s.fault_count == cfg.fault_ticks) || s.boot_flag;
        period   = (s.fault_count == cfg.fault_ticks) ? cfg.fault_blink_period
                                                      : cfg.boot_blink_period;
        if (blink_on)
        begin
            if (s.blink_count == '0)
            begin
                s.blink_count = period;
                s.led_state   = !s.led_state;
            end
            s.blink_count = s.blink_count - 16'd1;
        end

        // delayed output power decision
        if (s.enable_countdown != '0)
        begin
            s.enable_countdown = s.enable_countdown - 16'd1;
            if (s.enable_countdown == '0)
            begin
                if (!external_supply)
                begin
                    s.output_switch = 1'b1;
                end
                s.reset_countdown = cfg.reset_release_delay;
                s.power_flag      = 1'b1;
                mon               = 1'b1;
            end
        end

        // boot pin release
        if (s.boot_countdown != '0)
        begin
            s.boot_countdown = s.boot_countdown - 16'd1;
            if (s.boot_countdown == '0)
            begin
                s.boot_line = 1'b0;
            end
        end

        // button timing
        if (button_pressed)
        begin
            s.hold_count = s.hold_count + 16'd1;
            if (s.hold_count == cfg.long_press_ticks && s.power_flag)
            begin
                s.boot_flag  = !s.boot_flag;
                s.reset_line = 1'b0;
                if (s.boot_flag)
                begin
                    s.boot_line      = 1'b1;
                    s.boot_countdown = cfg.boot_release_delay;
                end
                else
                begin
                    s.led_state = 1'b1;
                end
                s.reset_countdown = 16'd1;
            end
        end
        else
        begin
            if (s.hold_count >= cfg.short_press_ticks &&
                s.hold_count < cfg.long_press_ticks)
            begin
                s.power_flag = !s.power_flag;
                if (s.power_flag)
                begin
                    s.reset_line       = 1'b0;
                    s.boot_line        = 1'b0;
                    s.input_switch     = 1'b1;
                    s.led_state        = 1'b1;
                    s.enable_countdown = cfg.power_enable_delay;
                    s.boot_flag        = 1'b0;
                    s.fault_count      = '0;
                end
                else
                begin
                    s = cut_power(s);
                end
            end
            s.hold_count = '0;
        end

        state_next = s;

        result.input_power_en  = s.input_switch;
        result.output_power_en = s.output_switch;
        result.target_reset_n  = s.reset_line;
        result.boot_select     = s.boot_line;
        result.led_lit         = s.led_state;
        result.power_on        = s.power_flag;
        result.boot_mode       = s.boot_flag;
        result.power_fault     = (s.fault_count == cfg.fault_ticks);
        result.monitor_start   = mon;
        result.reset_released  = rel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.hold_count       <= RESET_HOLD;
            state_reg.fault_count      <= '0;
            state_reg.reset_countdown  <= '0;
            state_reg.boot_countdown   <= '0;
            state_reg.enable_countdown <= '0;
            state_reg.blink_count      <= '0;
            state_reg.power_flag       <= 1'b0;
            state_reg.boot_flag        <= 1'b0;
            state_reg.input_switch     <= 1'b0;
            state_reg.output_switch    <= 1'b0;
            state_reg.reset_line       <= 1'b0;
            state_reg.boot_line        <= 1'b0;
            state_reg.led_state        <= 1'b1;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule
